@@ rtl/lohp_pkg.sv @@
`timescale 1ns / 1ps
package lohp_pkg;

	localparam int MAX_FIELD_BYTES_DEF = 16;

	typedef struct packed {
		logic       start_req;
		logic [7:0] data_byte;
	} lohp_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [1:0]  object_type;
		logic [31:0] object_size;
	} lohp_result_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TYPE = 2'd1,
		PH_SIZE = 2'd2
	} lohp_phase_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_TYPE = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	// Byte expected at a given position of each type word; zero past the end.
	function automatic logic [7:0] type_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] c;
		c = CH_NUL;
		case (k)
			2'd0: begin
				case (pos)
					3'd0: c = "c";
					3'd1: c = "o";
					3'd2: c = "m";
					3'd3: c = "m";
					3'd4: c = "i";
					3'd5: c = "t";
					3'd6: c = CH_SPACE;
					default: c = CH_NUL;
				endcase
			end
			2'd1: begin
				case (pos)
					3'd0: c = "t";
					3'd1: c = "r";
					3'd2: c = "e";
					3'd3: c = "e";
					3'd4: c = CH_SPACE;
					default: c = CH_NUL;
				endcase
			end
			2'd2: begin
				case (pos)
					3'd0: c = "b";
					3'd1: c = "l";
					3'd2: c = "o";
					3'd3: c = "b";
					3'd4: c = CH_SPACE;
					default: c = CH_NUL;
				endcase
			end
			default: begin
				case (pos)
					3'd0: c = "t";
					3'd1: c = "a";
					3'd2: c = "g";
					3'd3: c = CH_SPACE;
					default: c = CH_NUL;
				endcase
			end
		endcase
		return c;
	endfunction

endpackage

@@ rtl/lohp_parse.sv @@
`timescale 1ns / 1ps
module lohp_parse #(
	parameter int MAX_FIELD_BYTES = lohp_pkg::MAX_FIELD_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  lohp_pkg::lohp_item_t  item,
	output logic                  hit,
	output lohp_pkg::lohp_result_t res
);
	import lohp_pkg::*;

	localparam int CW = $clog2(MAX_FIELD_BYTES);

	lohp_phase_t phase_q, phase_d, phase_e;
	logic [2:0]  pos_q, pos_d, pos_e;
	logic [3:0]  mask_q, mask_d, mask_e, mask_n;
	logic [31:0] acc_q, acc_d, acc_e;
	logic [CW-1:0] cnt_q, cnt_d, cnt_e;
	logic        lead0_q, lead0_d, lead0_e;
	logic [1:0]  type_q, type_d;
	logic        done;
	logic [1:0]  done_k;
	logic [7:0]  b;
	logic [3:0]  digit;
	logic        is_digit;

	assign b        = item.data_byte;
	assign digit    = 4'(b - CH_ZERO);
	assign is_digit = (b inside {["0":"9"]});

	// A start byte restarts the header before the byte itself is examined.
	always_comb begin
		if (item.start_req) begin
			phase_e = PH_TYPE;
			pos_e   = '0;
			mask_e  = 4'hF;
			acc_e   = '0;
			cnt_e   = '0;
			lead0_e = 1'b0;
		end else begin
			phase_e = phase_q;
			pos_e   = pos_q;
			mask_e  = mask_q;
			acc_e   = acc_q;
			cnt_e   = cnt_q;
			lead0_e = lead0_q;
		end
	end

	always_comb begin
		mask_n = '0;
		done   = 1'b0;
		done_k = '0;
		for (int k = 0; k < 4; k++) begin
			if (mask_e[k] && type_char(2'(k), pos_e) == b) begin
				mask_n[k] = 1'b1;
				if (b == CH_SPACE) begin
					done   = 1'b1;
					done_k = 2'(k);
				end
			end
		end
	end

	// Next state.
	always_comb begin
		phase_d = phase_e;
		pos_d   = pos_e;
		mask_d  = mask_e;
		acc_d   = acc_e;
		cnt_d   = cnt_e;
		lead0_d = lead0_e;
		type_d  = type_q;
		case (phase_e)
			PH_TYPE: begin
				if (mask_n == '0) begin
					phase_d = PH_IDLE;
				end else if (done) begin
					phase_d = PH_SIZE;
					acc_d   = '0;
					cnt_d   = '0;
					lead0_d = 1'b0;
					type_d  = done_k;
				end else begin
					mask_d = mask_n;
					pos_d  = pos_e + 3'd1;
				end
			end
			PH_SIZE: begin
				if (b == CH_NUL || !is_digit || (cnt_e != '0 && lead0_e)
						|| cnt_e >= CW'(MAX_FIELD_BYTES - 1)) begin
					phase_d = PH_IDLE;
				end else begin
					acc_d   = (acc_e << 3) + (acc_e << 1) + {28'd0, digit};
					cnt_d   = cnt_e + CW'(1);
					lead0_d = (cnt_e == '0) && (digit == 4'd0);
				end
			end
			default: begin
				phase_d = phase_e;
			end
		endcase
	end

	// Result of the byte.
	always_comb begin
		hit             = 1'b0;
		res.status      = ST_OK;
		res.object_type = '0;
		res.object_size = '0;
		case (phase_e)
			PH_TYPE: begin
				if (mask_n == '0) begin
					hit        = 1'b1;
					res.status = ST_BAD_TYPE;
				end
			end
			PH_SIZE: begin
				if (b == CH_NUL) begin
					hit = 1'b1;
					if (cnt_e == '0) begin
						res.status = ST_BAD_SIZE;
					end else begin
						res.object_type = type_q;
						res.object_size = acc_e;
					end
				end else if (!is_digit || (cnt_e != '0 && lead0_e)
						|| cnt_e >= CW'(MAX_FIELD_BYTES - 1)) begin
					hit        = 1'b1;
					res.status = ST_BAD_SIZE;
				end
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pos_q   <= '0;
			mask_q  <= 4'hF;
			acc_q   <= '0;
			cnt_q   <= '0;
			lead0_q <= 1'b0;
			type_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			mask_q  <= mask_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			lead0_q <= lead0_d;
			type_q  <= type_d;
		end
	end

endmodule

@@ rtl/loose_object_header_parser_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Word
// item      in         item_valid/item_stall  start_req, data_byte
// result    out        result_valid/result_stall  status, object_type, object_size
//
// Each accepted word is held in the input stage, is parsed there against
// the header state, and any result is registered in the output register.
// One word is accepted per cycle while item_stall is low; a result is offered
// from the output register once its word has left the input stage.
// Reset clears the header state to idle and empties both stages.
// A stalled result holds the output register; a full input stage then stalls too.
module loose_object_header_parser_core #(
	parameter int MAX_FIELD_BYTES = lohp_pkg::MAX_FIELD_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  lohp_pkg::lohp_item_t   item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output lohp_pkg::lohp_result_t result
);
	import lohp_pkg::*;

	logic         valid_s1;
	lohp_item_t   item_s1;
	logic         res_valid_q;
	lohp_result_t res_q;
	logic         advance;
	logic         fire;
	logic         hit;
	lohp_result_t res;

	// The input stage moves whenever the output register is empty or being taken.
	assign advance    = !res_valid_q || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// The parser commits its state only when the stage word is consumed.
	lohp_parse #(
		.MAX_FIELD_BYTES(MAX_FIELD_BYTES)
	) u_parse (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (fire),
		.item  (item_s1),
		.hit   (hit),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("input stalled with an empty stage");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(valid_s1))
		else $error("result without a staged word");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.status == ST_OK || res_q.status == ST_BAD_TYPE
			|| res_q.status == ST_BAD_SIZE))
		else $error("illegal status code");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.status != ST_OK) |->
			(res_q.object_type == 2'd0 && res_q.object_size == 32'd0))
		else $error("error result carries type or size");

endmodule
